/* rtl/sscp_pkg.sv */
// ----------------------------------------------------------------------------
// sscp_pkg
// Shared constants, codes and types of the serial setting command parser.
// ----------------------------------------------------------------------------
package sscp_pkg;

   // line buffer geometry
   localparam int unsigned LINE_LIMIT_DEFAULT = 511;
   localparam int unsigned HEAD_DEPTH         = 11;
   localparam int unsigned NAME_DEPTH         = 10;

   // characters of the command language
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_QUERY  = 8'h3F;  // '?'
   localparam logic [7:0] CHAR_CHAN   = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_NAME   = 8'h62;  // 'b'
   localparam logic [7:0] CHAR_PERIOD = 8'h72;  // 'r'
   localparam logic [7:0] CHAR_COMMIT = 8'h77;  // 'w'
   localparam logic [7:0] DIGIT_ZERO  = 8'd48;
   localparam logic [7:0] DIGIT_NINE  = 8'd57;

   // command kinds as reported on the result channel
   localparam logic [2:0] KIND_UNKNOWN = 3'd0;
   localparam logic [2:0] KIND_QUERY   = 3'd1;
   localparam logic [2:0] KIND_CHAN    = 3'd2;
   localparam logic [2:0] KIND_NAME    = 3'd3;
   localparam logic [2:0] KIND_PERIOD  = 3'd4;
   localparam logic [2:0] KIND_COMMIT  = 3'd5;

   // settings after reset
   localparam logic [7:0]  CHANNEL_RESET = 8'h19;
   localparam logic [31:0] PERIOD_RESET  = 32'd20;

   typedef logic [HEAD_DEPTH-1:0][7:0] head_type;

   typedef struct packed {
      logic [7:0]                 channel;
      logic [31:0]                period;
      logic [3:0]                 name_len;
      logic [NAME_DEPTH-1:0][7:0] name_bytes;
   } settings_type;

   localparam settings_type SETTINGS_RESET = '{
      channel:    CHANNEL_RESET,
      period:     PERIOD_RESET,
      name_len:   4'd0,
      name_bytes: '0
   };

   typedef struct packed {
      logic [2:0]   command_kind;
      settings_type settings;
   } rsp_payload_type;

endpackage

/* rtl/sscp_if.sv */
// ----------------------------------------------------------------------------
// sscp channel interfaces
// Valid/ready channels for received bytes and for settings reports.
// ----------------------------------------------------------------------------
interface sscp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sscp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command_kind;
   logic [7:0]  channel_value;
   logic [31:0] period_value;
   logic [3:0]  name_length;
   logic [63:0] name_bytes_low;
   logic [15:0] name_bytes_high;

   modport source (output valid, output command_kind, output channel_value,
                   output period_value, output name_length, output name_bytes_low,
                   output name_bytes_high, input ready);
   modport sink   (input valid, input command_kind, input channel_value,
                   input period_value, input name_length, input name_bytes_low,
                   input name_bytes_high, output ready);
endinterface

/* rtl/sscp_decode.sv */
// ----------------------------------------------------------------------------
// sscp_decode
// Decodes a finished line and works out the settings that follow from it.
// ----------------------------------------------------------------------------
module sscp_decode #(
   parameter int unsigned POS_W = $clog2(sscp_pkg::LINE_LIMIT_DEFAULT + 1)
) (
   input  sscp_pkg::head_type     line_head,
   input  logic [POS_W-1:0]       line_length,
   input  sscp_pkg::settings_type cur_settings,
   output logic [2:0]             command_kind,
   output sscp_pkg::settings_type next_settings
);
   import sscp_pkg::*;

   logic [31:0]                d1, d2, d3;
   logic [7:0]                 chan_value;
   logic [31:0]                period_three, period_two;
   logic                       third_is_digit;
   logic [3:0]                 name_len;
   logic [NAME_DEPTH-1:0][7:0] name_bytes;

   // digits wrap as unsigned 32-bit values
   assign d1 = {24'd0, line_head[1]} - {24'd0, DIGIT_ZERO};
   assign d2 = {24'd0, line_head[2]} - {24'd0, DIGIT_ZERO};
   assign d3 = {24'd0, line_head[3]} - {24'd0, DIGIT_ZERO};

   assign chan_value     = d1[7:0] * 8'd10 + d2[7:0];
   assign period_three   = d1 * 32'd100 + d2 * 32'd10 + d3;
   assign period_two     = d1 * 32'd10 + d2;
   assign third_is_digit = (line_head[3] >= DIGIT_ZERO) && (line_head[3] <= DIGIT_NINE);

   // take name bytes until the line ends, a CR shows up, or the name is full
   always_comb begin
      logic run;
      run        = 1'b1;
      name_len   = 4'd0;
      name_bytes = '0;
      for (int i = 0; i < NAME_DEPTH; i++) begin
         run = run && (POS_W'(i) < line_length) && (line_head[i+1] != CHAR_CR);
         if (run) begin
            name_bytes[i] = line_head[i+1];
            name_len      = 4'(i + 1);
         end
      end
   end

   always_comb begin
      next_settings = cur_settings;
      unique case (line_head[0])
         CHAR_QUERY: begin
            command_kind = KIND_QUERY;
         end
         CHAR_CHAN: begin
            command_kind          = KIND_CHAN;
            next_settings.channel = chan_value;
         end
         CHAR_NAME: begin
            command_kind             = KIND_NAME;
            next_settings.name_len   = name_len;
            next_settings.name_bytes = name_bytes;
         end
         CHAR_PERIOD: begin
            command_kind         = KIND_PERIOD;
            next_settings.period = third_is_digit ? period_three : period_two;
         end
         CHAR_COMMIT: begin
            command_kind = KIND_COMMIT;
         end
         default: begin
            command_kind = KIND_UNKNOWN;
         end
      endcase
   end

endmodule

/* rtl/serial_setting_command_parser_unit.sv */
// ----------------------------------------------------------------------------
// serial_setting_command_parser_unit
// Collects received bytes into a line and decodes setting commands on CR.
// ----------------------------------------------------------------------------
// Report path: a CR beat's report is registered into main, or into skid
//   while main stalls. Throughput: one byte per cycle while skid is empty;
//   the line write and the decode are one registered pass, and a two-entry
//   output buffer keeps req open while one report waits to be taken.
// Reset: synchronous; clears the line head, write position and name, sets
//   channel to 25 and period to 20, and empties the output buffer.
// ----------------------------------------------------------------------------
module serial_setting_command_parser_unit #(
   parameter int unsigned LINE_LIMIT = sscp_pkg::LINE_LIMIT_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sscp_req_if.sink   req_bus,
   sscp_rsp_if.source rsp_bus
);
   import sscp_pkg::*;

   localparam int unsigned POS_W = $clog2(LINE_LIMIT + 1);

   // line state
   logic [POS_W-1:0] wpos_ff, wpos_in, wpos_step;
   head_type         head_ff, head_in, head_step;
   logic             below_limit;

   // settings state
   settings_type set_ff, set_in, set_dec;
   logic [2:0]   kind_dec;

   // output buffer: main register drives rsp, skid catches a report while main stalls
   rsp_payload_type main_ff, main_in, skid_ff, skid_in, new_rsp;
   logic            main_vld_ff, main_vld_in, skid_vld_ff, skid_vld_in;

   logic accept, is_cr, push, pop;

   assign req_bus.ready = !skid_vld_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_cr         = (req_bus.rx_byte == CHAR_CR);
   assign push          = accept && is_cr;
   assign pop           = main_vld_ff && rsp_bus.ready;

   // --- line write ----------------------------------------------------------
   // Below the limit, store the byte, advance, and zero the next slot.
   // At the limit, drop the byte and wrap the position to zero.
   assign below_limit = (wpos_ff < POS_W'(LINE_LIMIT));
   assign wpos_step   = below_limit ? (wpos_ff + POS_W'(1)) : '0;

   always_comb begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         head_step[i] = head_ff[i];
         if (below_limit && (wpos_ff == POS_W'(i))) begin
            head_step[i] = req_bus.rx_byte;
         end else if (below_limit && (wpos_step == POS_W'(i))) begin
            head_step[i] = 8'h00;
         end
      end
   end

   // --- decode the line as it stands after this beat's write ---------------
   sscp_decode #(
      .POS_W(POS_W)
   ) u_decode (
      .line_head     (head_step),
      .line_length   (wpos_step),
      .cur_settings  (set_ff),
      .command_kind  (kind_dec),
      .next_settings (set_dec)
   );

   // --- state update --------------------------------------------------------
   always_comb begin
      head_in = head_ff;
      wpos_in = wpos_ff;
      set_in  = set_ff;
      if (accept) begin
         head_in = head_step;
         wpos_in = is_cr ? '0 : wpos_step;
         if (is_cr) begin
            set_in = set_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         wpos_ff <= '0;
         set_ff  <= SETTINGS_RESET;
      end else begin
         head_ff <= head_in;
         wpos_ff <= wpos_in;
         set_ff  <= set_in;
      end
   end

   // --- output buffer -------------------------------------------------------
   assign new_rsp.command_kind = kind_dec;
   assign new_rsp.settings     = set_dec;

   always_comb begin
      main_in     = main_ff;
      skid_in     = skid_ff;
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         // req is held off; advance skid into main once main drains
         if (pop) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (main_vld_ff && !pop) begin
            skid_in     = new_rsp;
            skid_vld_in = 1'b1;
         end else begin
            main_in     = new_rsp;
            main_vld_in = 1'b1;
         end
      end else if (pop) begin
         main_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // --- result channel ------------------------------------------------------
   assign rsp_bus.valid           = main_vld_ff;
   assign rsp_bus.command_kind    = main_ff.command_kind;
   assign rsp_bus.channel_value   = main_ff.settings.channel;
   assign rsp_bus.period_value    = main_ff.settings.period;
   assign rsp_bus.name_length     = main_ff.settings.name_len;
   assign rsp_bus.name_bytes_low  = main_ff.settings.name_bytes[7:0];
   assign rsp_bus.name_bytes_high = main_ff.settings.name_bytes[9:8];

endmodule

/* bench/serial_setting_command_parser_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_setting_command_parser_unit_tb
// Self-checking bench: feeds received bytes on req, predicts every settings
// report that a carriage return causes and compares each rsp beat with it.
// ----------------------------------------------------------------------------
module serial_setting_command_parser_unit_tb;
   import sscp_pkg::*;

   localparam int unsigned LINE_LIMIT   = LINE_LIMIT_DEFAULT;
   localparam int          CYCLE_LIMIT  = 250000;
   localparam int          RANDOM_BYTES = 690;
   localparam int          SETTLE_TIME  = 10;    // cycles after the last report

   // one settings report as the rsp channel carries it
   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  channel;
      logic [31:0] period;
      logic [3:0]  name_len;
      logic [63:0] name_lo;
      logic [15:0] name_hi;
   } report_type;

   logic clock;
   logic reset;

   sscp_req_if req_bus ();
   sscp_rsp_if rsp_bus ();

   serial_setting_command_parser_unit #(
      .LINE_LIMIT (LINE_LIMIT)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // --------------------------------------------------------------------------
   // Shadow copy of the parser state
   // --------------------------------------------------------------------------
   logic [7:0]  line_head [HEAD_DEPTH];
   int          line_pos;
   logic [7:0]  chan_setting;
   logic [31:0] period_setting;
   logic [7:0]  name_store [NAME_DEPTH];
   int          name_count;

   report_type  pending_reports [$];

   int          mismatch_count;
   int          bytes_sent;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_off_cycles;

   // --------------------------------------------------------------------------
   // Clock, cycle watchdog
   // --------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Predictor
   // --------------------------------------------------------------------------
   task automatic reset_shadow();
      for (int i = 0; i < HEAD_DEPTH; i++) line_head[i] = 8'd0;
      for (int i = 0; i < NAME_DEPTH; i++) name_store[i] = 8'd0;
      line_pos       = 0;
      chan_setting   = CHANNEL_RESET;
      period_setting = PERIOD_RESET;
      name_count     = 0;
   endtask

   // ASCII value of a line position minus '0', wrapping as 32-bit unsigned
   function automatic logic [31:0] digit_at(int pos);
      return {24'd0, line_head[pos]} - {24'd0, DIGIT_ZERO};
   endfunction

   // Advance the shadow state by one accepted byte; queue a report on CR.
   task automatic accept_byte(input logic [7:0] b);
      report_type rep;
      int         n;
      if (line_pos < LINE_LIMIT) begin
         if (line_pos < HEAD_DEPTH) line_head[line_pos] = b;
         line_pos++;
         if (line_pos < HEAD_DEPTH) line_head[line_pos] = 8'd0;
      end else begin
         // full line: drop the byte and wrap the write position
         line_pos = 0;
      end
      if (b != CHAR_CR) return;

      rep.kind = KIND_UNKNOWN;
      case (line_head[0])
         CHAR_QUERY:  rep.kind = KIND_QUERY;
         CHAR_COMMIT: rep.kind = KIND_COMMIT;
         CHAR_CHAN: begin
            rep.kind     = KIND_CHAN;
            chan_setting = 8'(digit_at(1) * 32'd10 + digit_at(2));
         end
         CHAR_NAME: begin
            rep.kind = KIND_NAME;
            for (int i = 0; i < NAME_DEPTH; i++) name_store[i] = 8'd0;
            n = 0;
            // copy until ten bytes, a CR, or the line length is reached
            while (n < NAME_DEPTH && n < line_pos) begin
               if (line_head[n + 1] == CHAR_CR) break;
               name_store[n] = line_head[n + 1];
               n++;
            end
            name_count = n;
         end
         CHAR_PERIOD: begin
            rep.kind = KIND_PERIOD;
            if (line_head[3] >= DIGIT_ZERO && line_head[3] <= DIGIT_NINE)
               period_setting = digit_at(1) * 32'd100 + digit_at(2) * 32'd10 + digit_at(3);
            else
               period_setting = digit_at(1) * 32'd10 + digit_at(2);
         end
         default: rep.kind = KIND_UNKNOWN;
      endcase
      line_pos = 0;

      rep.channel  = chan_setting;
      rep.period   = period_setting;
      rep.name_len = 4'(name_count);
      rep.name_lo  = '0;
      rep.name_hi  = '0;
      for (int i = 0; i < NAME_DEPTH; i++) begin
         if (i < name_count) begin
            if (i < 8) rep.name_lo[8*i +: 8] = name_store[i];
            else       rep.name_hi[8*(i-8) +: 8] = name_store[i];
         end
      end
      pending_reports.push_back(rep);
   endtask

   // --------------------------------------------------------------------------
   // Report checker: sample each rsp beat at the rising edge
   // --------------------------------------------------------------------------
   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : report_checker
      report_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected report, expected none, actual kind %0h",
                     $time, rsp_bus.command_kind);
         end else begin
            want = pending_reports.pop_front();
            check_field("command_kind",    64'(want.kind),     64'(rsp_bus.command_kind));
            check_field("channel_value",   64'(want.channel),  64'(rsp_bus.channel_value));
            check_field("period_value",    64'(want.period),   64'(rsp_bus.period_value));
            check_field("name_length",     64'(want.name_len), 64'(rsp_bus.name_length));
            check_field("name_bytes_low",  want.name_lo,       rsp_bus.name_bytes_low);
            check_field("name_bytes_high", 64'(want.name_hi),  64'(rsp_bus.name_bytes_high));
         end
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: random ready, plus a counted hold-off on request
   // --------------------------------------------------------------------------
   initial begin : report_receiver
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Sender helpers; every call starts and ends at a falling edge
   // --------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      // idle for a random number of cycles before the beat
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      accept_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_line(string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
      send_byte(CHAR_CR);
   endtask

   function automatic logic [7:0] any_but_cr();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CHAR_CR);
      return b;
   endfunction

   // drop valid and hold until every queued report has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Directed tests
   // --------------------------------------------------------------------------

   // query right after reset reports the reset settings
   task automatic test_reset_settings();
      send_line("?");
      wait_for_drain();
   endtask

   task automatic test_channel_command();
      send_line("a42");
      send_line("a99");
      send_line("a00");
      // stale positions: CR and the zero behind it take part in the sum
      send_line("a");
      // non-digits wrap
      send_line("aZ~");
      wait_for_drain();
   endtask

   task automatic test_period_command();
      send_line("r123");
      send_line("r999");
      send_line("r45");        // third position is the CR, so two digits
      send_line("r000");
      send_line("r:/");        // non-digits, with 32-bit wrap below zero
      wait_for_drain();
   endtask

   task automatic test_name_command();
      send_line("bHELLOWORLD12");  // only ten bytes kept
      send_line("bab");
      send_line("b");              // empty name
      wait_for_drain();
   endtask

   task automatic test_other_commands();
      send_line("w");
      send_line("x7");
      send_line("");               // empty line: unknown
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CHAR_CR);
      wait_for_drain();
   endtask

   // full line: the CR at the limit is dropped, but the line still decodes
   task automatic test_full_line();
      send_byte(CHAR_NAME);
      for (int i = 1; i < LINE_LIMIT; i++) send_byte(any_but_cr());
      send_byte(CHAR_CR);
      // overrun: the byte at the limit is dropped and a new line starts
      for (int i = 0; i < LINE_LIMIT; i++) send_byte(any_but_cr());
      send_byte(CHAR_QUERY);
      send_line("a12");
      wait_for_drain();
   endtask

   // hold the receiver off long enough for the block to stall req
   task automatic test_backpressure();
      hold_off_cycles = 150;
      for (int i = 0; i < 12; i++) send_line("?");
      send_line("r77");
      wait_for_drain();
   endtask

   // --------------------------------------------------------------------------
   // Random traffic
   // --------------------------------------------------------------------------
   task automatic send_random_line();
      int         pick;
      int         len;
      logic [7:0] cmd;
      logic [7:0] b;
      pick = $urandom_range(99);
      if ($urandom_range(399) == 0) begin
         // rare overlong line around the limit
         send_byte(any_but_cr());
         len = $urandom_range(LINE_LIMIT - 12, LINE_LIMIT + 20);
         for (int i = 0; i < len; i++) send_byte(any_but_cr());
         send_byte(CHAR_CR);
      end else if (pick < 80) begin
         // well-formed command with random content
         case ($urandom_range(4))
            0:       cmd = CHAR_QUERY;
            1:       cmd = CHAR_CHAN;
            2:       cmd = CHAR_NAME;
            3:       cmd = CHAR_PERIOD;
            default: cmd = CHAR_COMMIT;
         endcase
         case (cmd)
            CHAR_CHAN:   len = $urandom_range(4) == 0 ? $urandom_range(3) : 2;
            CHAR_PERIOD: len = $urandom_range(1, 4);
            CHAR_NAME:   len = $urandom_range(13);
            default:     len = $urandom_range(2);
         endcase
         send_byte(cmd);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) < 8)
               b = (cmd == CHAR_NAME) ? 8'($urandom_range(32, 126))
                                      : DIGIT_ZERO + 8'($urandom_range(9));
            else
               b = 8'($urandom_range(255));
            send_byte(b);
         end
         send_byte(CHAR_CR);
      end else begin
         // noise: random bytes, line often left open
         len = $urandom_range(14);
         for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
         if ($urandom_range(9) < 7) send_byte(CHAR_CR);
      end
   endtask

   task automatic test_random_traffic();
      int start;
      // sender idles 22 / receiver 50, then swapped, then neither
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 22; recv_idle_pct = 50; end
            1: begin send_idle_pct = 50; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         start = bytes_sent;
         while (bytes_sent - start < RANDOM_BYTES / 3) send_random_line();
         wait_for_drain();
      end
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'd0;
      mismatch_count  = 0;
      bytes_sent      = 0;
      cycle_count     = 0;
      hold_off_cycles = 0;
      send_idle_pct   = 22;
      recv_idle_pct   = 50;
      reset_shadow();

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_settings();
      test_channel_command();
      test_period_command();
      test_name_command();
      test_other_commands();
      test_full_line();
      test_backpressure();
      test_random_traffic();

      // drain, then let the block settle so stray reports show up
      wait_for_drain();
      repeat (SETTLE_TIME) @(negedge clock);

      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
